// ----- rtl/core/utf8_to_utf16_transcoder_macros.svh -----
// assertion macros for the utf-8 to utf-16 transcoder
// expects clk and rst_n in the scope of each use
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define UTU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define UTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/utu_pkg.sv -----
// shared types and constants of the utf-8 to utf-16 transcoder
// no dependencies
package utu_pkg;

  typedef enum logic [0:0] {
    CFG_LITTLE_ENDIAN = 1'b0,
    CFG_EMIT_BOM      = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic little_endian;
    logic emit_bom;
  } cfg_t;

  // one decoded item: up to four output bytes in send order
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            data;
    logic            frame_last;
    logic            err;
  } job_t;

  localparam logic [15:0] BOM_UNIT  = 16'hFEFF;
  localparam logic [15:0] SUR_HIGH  = 16'hD800;
  localparam logic [15:0] SUR_LOW   = 16'hDC00;
  localparam logic [20:0] SUPP_BASE = 21'h010000;
  localparam logic [20:0] SUPP_MAX  = 21'h10FFFF;

  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

endpackage

// ----- rtl/core/utu_in_if.sv -----
// input channel of the transcoder: utf-8 bytes with frame marker
// no dependencies
interface utu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_last;

  modport source (output valid, output in_byte, output frame_last, input ready);
  modport sink   (input valid, input in_byte, input frame_last, output ready);
endinterface

// ----- rtl/core/utu_out_if.sv -----
// result channel of the transcoder: utf-16 bytes with status flags
// no dependencies
interface utu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       frame_done;
  logic       stopped_error;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output frame_done, output stopped_error, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input frame_done, input stopped_error, output ready);
endinterface

// ----- rtl/core/utu_front.sv -----
// front end: accepts utf-8 beats, tracks sequence state, builds output jobs
// depends on utu_pkg, utu_in_if and the macros header
`include "utf8_to_utf16_transcoder_macros.svh"

module utu_front
  import utu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg_i,
  utu_in_if.sink   in_ch,
  input  logic     full_i,
  output logic     push_o,
  output job_t     job_o
);

  logic [1:0]  pending_r, pending_nxt;
  logic [1:0]  seq_len_r, seq_len_nxt;
  logic [20:0] accum_r, accum_nxt;
  logic        halted_r, halted_nxt;
  logic        at_start_r, at_start_nxt;

  logic        accept;
  logic        bom;
  logic [1:0]  unit_cnt;
  logic [15:0] unit_a, unit_b;
  logic [1:0]  nunits;
  logic [15:0] slot0, slot1;
  logic [2:0]  nbytes;
  logic        err;

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && !full_i;
  assign bom         = at_start_r && cfg_i.emit_bom;

  always_comb begin
    logic [7:0]  b;
    logic [20:0] v;
    logic [19:0] w;
    b            = in_ch.in_byte;
    v            = '0;
    w            = '0;
    pending_nxt  = pending_r;
    seq_len_nxt  = seq_len_r;
    accum_nxt    = accum_r;
    halted_nxt   = halted_r;
    at_start_nxt = 1'b0;
    unit_cnt     = 2'd0;
    unit_a       = '0;
    unit_b       = '0;
    if (!halted_r) begin
      if (pending_r != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          halted_nxt  = 1'b1;
          pending_nxt = 2'd0;
        end else begin
          v           = {accum_r[14:0], b[5:0]};
          accum_nxt   = v;
          pending_nxt = pending_r - 2'd1;
          if (pending_r == 2'd1) begin
            if (seq_len_r == SEQ_FOUR) begin
              w = 20'(v - SUPP_BASE);
              if (v < SUPP_BASE || v > SUPP_MAX) begin
                halted_nxt = 1'b1;
              end else begin
                unit_cnt = 2'd2;
                unit_a   = SUR_HIGH | {6'd0, w[19:10]};
                unit_b   = SUR_LOW | {6'd0, w[9:0]};
              end
            end else begin
              unit_cnt = 2'd1;
              unit_a   = v[15:0];
            end
          end
        end
      end else if (!b[7]) begin
        unit_cnt = 2'd1;
        unit_a   = {8'd0, b};
      end else if (b[7:5] == 3'b110) begin
        accum_nxt   = {16'd0, b[4:0]};
        seq_len_nxt = SEQ_TWO;
        pending_nxt = SEQ_TWO;
      end else if (b[7:4] == 4'b1110) begin
        accum_nxt   = {17'd0, b[3:0]};
        seq_len_nxt = SEQ_THREE;
        pending_nxt = SEQ_THREE;
      end else if (b[7:3] == 5'b11110) begin
        accum_nxt   = {18'd0, b[2:0]};
        seq_len_nxt = SEQ_FOUR;
        pending_nxt = SEQ_FOUR;
      end
    end
    // a sequence cut off by the frame end
    if (in_ch.frame_last && pending_nxt != 2'd0 && !halted_nxt) begin
      halted_nxt  = 1'b1;
      pending_nxt = 2'd0;
    end
    err = halted_nxt;
    if (in_ch.frame_last) begin
      pending_nxt  = 2'd0;
      seq_len_nxt  = 2'd0;
      accum_nxt    = '0;
      halted_nxt   = 1'b0;
      at_start_nxt = 1'b1;
    end
  end

  // the mark only ever joins a single unit, since a frame opens on a lead byte
  always_comb begin
    if (bom) begin
      slot0  = BOM_UNIT;
      slot1  = unit_a;
      nunits = (unit_cnt == 2'd0) ? 2'd1 : 2'd2;
    end else begin
      slot0  = unit_a;
      slot1  = unit_b;
      nunits = unit_cnt;
    end
    nbytes = {nunits, 1'b0};
  end

  always_comb begin
    if (cfg_i.little_endian) begin
      job_o.bytes = {slot1[15:8], slot1[7:0], slot0[15:8], slot0[7:0]};
    end else begin
      job_o.bytes = {slot1[7:0], slot1[15:8], slot0[7:0], slot0[15:8]};
    end
    job_o.data       = (nbytes != 3'd0);
    job_o.last_idx   = (nbytes == 3'd0) ? 2'd0 : 2'(nbytes - 3'd1);
    job_o.frame_last = in_ch.frame_last;
    job_o.err        = err;
    push_o           = accept && (nbytes != 3'd0 || in_ch.frame_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      seq_len_r  <= '0;
      accum_r    <= '0;
      halted_r   <= 1'b0;
      at_start_r <= 1'b1;
    end else if (accept) begin
      pending_r  <= pending_nxt;
      seq_len_r  <= seq_len_nxt;
      accum_r    <= accum_nxt;
      halted_r   <= halted_nxt;
      at_start_r <= at_start_nxt;
    end
  end

  `UTU_ASSERT_NEXT(a_frame_end_clears, accept && in_ch.frame_last, at_start_r && !halted_r && pending_r == 2'd0, "state not cleared after frame end")
  `UTU_ASSERT_NOW(a_halt_no_pending, halted_r, pending_r == 2'd0, "pending count held while halted")

endmodule

// ----- rtl/core/utu_queue.sv -----
// short job queue between front and back end, flop storage
// depends on utu_pkg and the macros header
`include "utf8_to_utf16_transcoder_macros.svh"

module utu_queue
  import utu_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o,
  output logic full_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty_o = (count_r == CNT_W'(0));
  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign head_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= job_i;
    end
  end

  `UTU_ASSERT_NOW(a_no_overflow, push_i, !full_o, "push into full queue")
  `UTU_ASSERT_NOW(a_no_underflow, pop_i, !empty_o, "pop from empty queue")

endmodule

// ----- rtl/core/utu_back.sv -----
// back end: walks the bytes of each queued job into the output register
// depends on utu_pkg, utu_out_if and the macros header
`include "utf8_to_utf16_transcoder_macros.svh"

module utu_back
  import utu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head_i,
  input  logic      empty_i,
  output logic      pop_o,
  utu_out_if.source out_ch
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r;
  logic       byte_valid_r, run_last_r, frame_done_r, error_r;
  logic [1:0] idx_r, idx_nxt;

  logic       load;
  logic       take;
  logic       at_end;

  assign load   = !out_valid_r || out_ch.ready;
  assign take   = load && !empty_i;
  assign at_end = (idx_r == head_i.last_idx);
  assign pop_o  = take && at_end;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (take) begin
      idx_nxt       = at_end ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (load) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r       <= head_i.data ? head_i.bytes[idx_r] : 8'd0;
      byte_valid_r <= head_i.data;
      run_last_r   <= at_end;
      frame_done_r <= at_end && head_i.frame_last;
      error_r      <= head_i.err;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = byte_r;
  assign out_ch.byte_valid    = byte_valid_r;
  assign out_ch.run_last      = run_last_r;
  assign out_ch.frame_done    = frame_done_r;
  assign out_ch.stopped_error = error_r;

  `UTU_ASSERT_NOW(a_marker_ends_frame, out_valid_r && !byte_valid_r, run_last_r && frame_done_r, "end marker not at frame end")
  `UTU_ASSERT_NOW(a_done_is_last, out_valid_r && frame_done_r, run_last_r, "frame end not on last beat of item")

endmodule

// ----- rtl/core/utf8_to_utf16_transcoder.sv -----
// utf-8 to utf-16 transcoder: front end, job queue and byte serializer.
// a result beat passes through the job queue and then the output register.
// throughput: one output beat per cycle while out_ch.ready holds; an input beat is
// taken every cycle while the job queue has room; a job leaves it on its last beat.
// reset (rst_n low, synchronous) clears config, sequence state and queue.
module utf8_to_utf16_transcoder
  import utu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  cfg_idx_t   cfg_index,
  input  logic [0:0] cfg_wdata,
  utu_in_if.sink     in_ch,
  utu_out_if.source  out_ch
);

  cfg_t cfg_r, cfg_nxt;
  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t job;
  job_t head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LITTLE_ENDIAN: cfg_nxt.little_endian = cfg_wdata[0];
        CFG_EMIT_BOM:      cfg_nxt.emit_bom      = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  utu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_i  (cfg_r),
    .in_ch  (in_ch),
    .full_i (full),
    .push_o (push),
    .job_o  (job)
  );

  utu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  utu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule
